[src/mtbd_pkg.sv]
// Shared constants and functions for the MT19937 draw block.
// Holds the twister geometry, the tempering function and the mask smear.
// No dependencies.
`default_nettype none
package mtbd_pkg;

  localparam int unsigned Words     = 624;
  localparam int unsigned Shift     = 397;
  localparam int unsigned PosW      = $clog2(Words);
  localparam logic [31:0] MtMatrix  = 32'h9908_B0DF;
  localparam logic [31:0] MtUpper   = 32'h8000_0000;
  localparam logic [31:0] MtLower   = 32'h7FFF_FFFF;
  localparam logic [31:0] SeedMult  = 32'd1812433253;
  localparam int unsigned DrawW     = 53;
  localparam int unsigned RangeW    = 31;

  typedef enum logic {
    CMD_UNIT    = 1'b0,
    CMD_BOUNDED = 1'b1
  } cmd_e;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] smear(input logic [31:0] t);
    logic [31:0] m;
    m = t;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

endpackage
`default_nettype wire

[src/mtbd_gen.sv]
// Twist of one state word and tempering of the result.
// Uses mtbd_pkg for the twister constants and the tempering function.
`default_nettype none
module mtbd_gen
  import mtbd_pkg::*;
(
  input  wire logic [31:0] cur_i,
  input  wire logic [31:0] nxt_i,
  input  wire logic [31:0] far_i,
  output logic      [31:0] word_o,
  output logic      [31:0] out_o
);

  logic [31:0] y;

  always_comb begin
    y      = (cur_i & MtUpper) | (nxt_i & MtLower);
    word_o = far_i ^ (y >> 1) ^ (y[0] ? MtMatrix : 32'd0);
    out_o  = temper(word_o);
  end

endmodule
`default_nettype wire

[src/mt19937_bounded_and_unit_draws.sv]
// Top level: MT19937 generator answering unit and bounded draws.
// Uses mtbd_pkg and mtbd_gen; the 624-word state lives in one RAM here.
//
// channel   dir  payload
// s_axis    in   tdata: range_size[30:0]; tuser: cmd
// m_axis    out  tdata: draw_value[52:0]
// cfg       in   cfg_data_i: seed_value
//
// Each generator output is a RAM read, then a twist and write back.
// A unit draw takes two generator outputs; a bounded draw one per try; a bound of one none.
// After reset and every seed write a seed pass over all 624 words runs, no input taken.
// A finished result waits in the output register; the next request is still taken.
// Seed writes are taken only while idle or seeding; input is held off during a write.
`default_nettype none
module mt19937_bounded_and_unit_draws
  import mtbd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // range_size[30:0], zero pad
  input  wire logic        s_axis_tuser_i,   // cmd
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [55:0] m_axis_tdata_o,   // draw_value[52:0], zero pad
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [31:0]       mem [Words];
  logic [31:0]       rd_nxt_q, rd_far_q;
  logic [PosW-1:0]   pos_q, seed_idx_q;
  logic [PosW-1:0]   addr_nxt, addr_far;
  logic [PosW:0]     far_sum;
  logic [31:0]       cur_q, prev_q, seed_q;
  logic [31:0]       seed_mix, seed_next;
  logic [31:0]       top_q, mask_q, top_in;
  logic              cmd_q, phase_q;
  logic [26:0]       hi_q;
  logic [DrawW-1:0]  result_q, out_q;
  logic              out_valid_q;
  logic [31:0]       new_word, temp_out, masked;
  logic              load_out, mem_we;
  logic [PosW-1:0]   mem_wa;
  logic [31:0]       mem_wd;

  assign far_sum  = {1'b0, pos_q} + (PosW+1)'(Shift);
  assign addr_far = (far_sum >= (PosW+1)'(Words)) ? PosW'(far_sum - (PosW+1)'(Words))
                                                  : far_sum[PosW-1:0];
  assign addr_nxt = (pos_q == PosW'(Words - 1)) ? '0 : pos_q + PosW'(1);

  assign seed_mix  = prev_q ^ (prev_q >> 30);
  assign seed_next = seed_mix * SeedMult + 32'({seed_idx_q} + 11'd1);

  assign top_in = {1'b0, s_axis_tdata_i[RangeW-1:0]} - 32'd1;
  assign masked = temp_out & mask_q;

  mtbd_gen u_gen (
    .cur_i  (cur_q),
    .nxt_i  (rd_nxt_q),
    .far_i  (rd_far_q),
    .word_o (new_word),
    .out_o  (temp_out)
  );

  assign mem_we = (state_q == ST_SEED) || (state_q == ST_GEN);
  assign mem_wa = (state_q == ST_SEED) ? seed_idx_q : pos_q;
  assign mem_wd = (state_q == ST_SEED) ? prev_q : new_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_nxt_q <= mem[addr_nxt];
    rd_far_q <= mem[addr_far];
  end

  assign s_axis_tready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == ST_IDLE) || (state_q == ST_SEED);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};
  assign load_out        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      seed_q      <= '0;
      prev_q      <= '0;
      seed_idx_q  <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      cmd_q       <= CMD_UNIT;
      cur_q       <= '0;
      top_q       <= '0;
      mask_q      <= '0;
      hi_q        <= '0;
      result_q    <= '0;
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q     <= cfg_data_i;
        prev_q     <= cfg_data_i;
        seed_idx_q <= '0;
        state_q    <= ST_SEED;
      end else begin
        unique case (state_q)
          ST_SEED: begin
            if (seed_idx_q == '0) begin
              cur_q <= prev_q;
            end
            prev_q <= seed_next;
            if (seed_idx_q == PosW'(Words - 1)) begin
              pos_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              seed_idx_q <= seed_idx_q + PosW'(1);
            end
          end
          ST_IDLE: begin
            if (s_axis_tvalid_i) begin
              cmd_q   <= s_axis_tuser_i;
              top_q   <= top_in;
              mask_q  <= smear(top_in);
              phase_q <= 1'b0;
              if ((s_axis_tuser_i == CMD_BOUNDED) && (top_in == '0)) begin
                result_q <= '0;
                state_q  <= ST_FIN;
              end else begin
                state_q <= ST_GEN;
              end
            end
          end
          ST_READ: begin
            state_q <= ST_GEN;
          end
          ST_GEN: begin
            cur_q <= rd_nxt_q;
            pos_q <= addr_nxt;
            if (cmd_q == CMD_UNIT) begin
              if (!phase_q) begin
                hi_q    <= temp_out[31:5];
                phase_q <= 1'b1;
                state_q <= ST_READ;
              end else begin
                result_q <= {hi_q, temp_out[31:6]};
                state_q  <= ST_FIN;
              end
            end else if (masked <= top_q) begin
              result_q <= DrawW'(masked);
              state_q  <= ST_FIN;
            end else begin
              state_q <= ST_READ;
            end
          end
          ST_FIN: begin
            if (load_out) begin
              out_q   <= result_q;
              state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_SEED;
        endcase
      end
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(Words)) else $error("state position out of range");

  a_cfg_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (state_q == ST_SEED))
    else $error("seed write did not reseed");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && !cfg_valid_i) |=>
      (pos_q == (($past(pos_q) == PosW'(Words - 1)) ? '0 : $past(pos_q) + PosW'(1))))
    else $error("position did not advance by one");

  a_bound_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && cmd_q == CMD_BOUNDED) |-> (result_q <= DrawW'(top_q)))
    else $error("bounded draw above bound");

  seed_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED && seed_idx_q == '0 && !cfg_valid_i) |-> (prev_q == seed_q))
    else $error("seed pass did not start from seed");

endmodule
`default_nettype wire

[verif/tb_mt19937_bounded_and_unit_draws.sv]
// Testbench for the MT19937 unit and bounded draw block.
// Predicts draws with its own twister copy and scoreboard class; depends on mtbd_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb_mt19937_bounded_and_unit_draws;
  import mtbd_pkg::*;

  class draw_scoreboard;
    logic [31:0] mt_state[624];
    int unsigned mt_pos;
    logic [52:0] pending_draws[$];
    int unsigned mismatches;

    function void reseed(logic [31:0] s);
      logic [31:0] p;
      mt_state[0] = s;
      for (int i = 1; i < 624; i++) begin
        p = mt_state[i-1];
        mt_state[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
      end
      mt_pos = 624;
    endfunction

    function void add_draw(logic [52:0] d);
      pending_draws = {pending_draws, d};
    endfunction

    function logic [31:0] next_output();
      logic [31:0] y, v;
      if (mt_pos >= 624) begin
        for (int i = 0; i < 624; i++) begin
          y = (mt_state[i] & 32'h8000_0000) | (mt_state[(i+1)%624] & 32'h7FFF_FFFF);
          v = mt_state[(i+397)%624] ^ (y >> 1);
          if (y[0]) v = v ^ 32'h9908_B0DF;
          mt_state[i] = v;
        end
        mt_pos = 0;
      end
      y = mt_state[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function void note_request(cmd_e cmd, logic [30:0] n);
      logic [63:0] a, b;
      logic [31:0] top, mask, v;
      if (cmd == CMD_UNIT) begin
        a = next_output() >> 5;
        b = next_output() >> 6;
        add_draw(53'((a << 26) + b));
      end else begin
        top = {1'b0, n} - 32'd1;
        if (top == 0) add_draw('0);
        else begin
          mask = top;
          for (int s = 1; s < 32; s = s * 2) mask = mask | (mask >> s);
          do v = next_output() & mask; while (v > top);
          add_draw(53'(v));
        end
      end
    endfunction

    function void check_draw(logic [55:0] data);
      logic [52:0] want;
      if (pending_draws.size() == 0 || data[55:53] != 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected draw %h", data);
        if (pending_draws.size() != 0) void'(pending_draws.pop_front());
        return;
      end
      want = pending_draws.pop_front();
      if (want != data[52:0]) begin
        mismatches++;
        if (mismatches <= 10) $display("draw mismatch: expected %h actual %h", want, data[52:0]);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  draw_scoreboard sb;
  int send_idle_pct, stall_pct;
  int unsigned quiet_cycles;
  bit timed_out;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  mt19937_bounded_and_unit_draws DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_draw(m_axis_tdata_o);
    if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)
        || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(cmd_e cmd, logic [30:0] n);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {1'b0, n};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(cmd, n);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_draws.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] s);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.reseed(s);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_requests(int count);
    logic [30:0] n;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: n = 31'($urandom_range(1, 3));
        1: n = 31'($urandom_range(1, 300));
        2: n = 31'(1) << $urandom_range(30);
        3: n = (31'(1) << $urandom_range(30)) + 31'(1);
        default: n = 31'($urandom);
      endcase
      send_request(cmd_e'($urandom_range(1)), n);
    end
  endtask

  initial begin
    sb = new();
    sb.reseed(32'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_request(CMD_UNIT, '0);
    send_request(CMD_BOUNDED, 31'd1);
    send_request(CMD_BOUNDED, 31'd0);
    send_request(CMD_BOUNDED, 31'd2);
    send_request(CMD_BOUNDED, 31'h7FFF_FFFF);
    send_request(CMD_BOUNDED, 31'h4000_0000);
    send_request(CMD_BOUNDED, 31'h4000_0001);
    send_request(CMD_BOUNDED, 31'h5555_5555);
    send_request(CMD_BOUNDED, 31'h2AAA_AAAA);
    send_request(CMD_UNIT, 31'h7FFF_FFFF);
    send_request(CMD_BOUNDED, 31'd3);
    write_seed(32'hFFFF_FFFF);
    send_request(CMD_UNIT, '0);
    send_request(CMD_BOUNDED, 31'd0);
    random_requests(400);
    write_seed(32'd5489);
    send_idle_pct = 86;
    random_requests(350);
    drain();
    stall_pct = 86;
    send_idle_pct = 0;
    random_requests(350);
    write_seed($urandom);
    send_idle_pct = 29;
    stall_pct = 29;
    random_requests(350);
    write_seed(32'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    random_requests(350);
    drain();
    if (sb.mismatches == 0 && sb.pending_draws.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
